FILE: sv/dspv_pkg.sv
`timescale 1ns / 1ps

package dspv_pkg;

    // text limits and field widths
    localparam int MAX_TEXT_BYTES = 10;
    localparam int COUNT_W        = $clog2(MAX_TEXT_BYTES + 1);
    localparam int ACC_W          = 14;
    localparam int ACC_EXT_W      = 17;
    localparam int CODE_W         = 26;

    localparam logic [ACC_W-1:0] ACC_LIMIT = 14'd9999;
    localparam logic [ACC_W-1:0] YEAR_MIN  = 14'd1970;
    localparam logic [ACC_W-1:0] YEAR_MAX  = 14'd2038;
    localparam logic [ACC_W-1:0] MONTH_MAX = 14'd12;
    localparam logic [ACC_W-1:0] MONTH_FEB = 14'd2;
    localparam logic [ACC_W-1:0] MONTH_JAN = 14'd1;

    localparam logic [CODE_W-1:0] YEAR_SCALE  = 26'd10000;
    localparam logic [CODE_W-1:0] MONTH_SCALE = 26'd100;
    localparam logic [CODE_W-1:0] CODE_MIN    = 26'd19700101;
    localparam logic [CODE_W-1:0] CODE_MAX    = 26'd20380131;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        FLD_YEAR,
        FLD_MONTH,
        FLD_DAY,
        FLD_PAST
    } t_field;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [ACC_W-1:0] year;
        logic [ACC_W-1:0] month;
        logic [ACC_W-1:0] day;
    } t_ymd;

    // days in a non-leap month, month numbered from 1
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd2:    len = 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: sv/date_string_parse_validate.sv
`timescale 1ns / 1ps
// path: a last-marked byte moves from the input register to the check register, then to the result register
// throughput: one byte per cycle while no last-marked byte waits on a stalled check stage
// the pipeline holds its place while the master side stalls, so bytes keep flowing
// until a last-marked byte waits for an occupied check stage
// reset: synchronous, active low; clears all valid flags and the parse state

module date_string_parse_validate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: one text byte per request
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    // master side: one date result per text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [25:0] date_code, [31:26] zero
    output logic        m_axis_tuser    // [0] date_valid
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;

    // check register holds the finished year, month and day of one text
    logic           r_chk_valid;
    dspv_pkg::t_ymd r_chk_ymd;

    // result register
    logic                          r_out_valid;
    logic                          r_out_ok;
    logic [dspv_pkg::CODE_W-1:0]   r_out_code;

    logic                          out_free;
    logic                          chk_free;
    logic                          in_step;
    logic                          in_free;
    logic                          in_take;
    dspv_pkg::t_ymd                parse_ymd;
    logic                          chk_ok;
    logic [dspv_pkg::CODE_W-1:0]   chk_code;

    // handshake chain: a stage moves when the stage behind it is free
    assign out_free = !r_out_valid || m_axis_tready;
    assign chk_free = !r_chk_valid || out_free;
    // only the last byte of a text needs room in the check register
    assign in_step  = r_in_valid && (!r_in_last || chk_free);
    assign in_free  = !r_in_valid || in_step;
    assign in_take  = s_axis_tvalid && in_free;

    assign s_axis_tready = in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // byte parser: field split, atoi-style digit accumulation
    dspv_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_step),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_ymd   (parse_ymd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_valid <= 1'b0;
        end else if (chk_free) begin
            r_chk_valid <= in_step && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chk_free && in_step && r_in_last) begin
            r_chk_ymd <= parse_ymd;
        end
    end

    // month, day-of-month and epoch range checks, code assembly
    dspv_check u_check (
        .i_ymd  (r_chk_ymd),
        .o_ok   (chk_ok),
        .o_code (chk_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_chk_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_chk_valid) begin
            r_out_ok   <= chk_ok;
            r_out_code <= chk_code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tdata  = {{(32 - dspv_pkg::CODE_W){1'b0}}, r_out_code};

    // a valid date always lands inside the supported epoch window
    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ok) |->
            ((r_out_code >= dspv_pkg::CODE_MIN) && (r_out_code <= dspv_pkg::CODE_MAX)))
        else $error("valid date code out of range");

    // a rejected date carries all ones
    a_bad_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_code == '1))
        else $error("rejected date without all-ones code");

    // an empty input register never blocks the slave side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("slave side blocked with empty input register");

    // a check entry waiting on a stalled result stays put
    a_chk_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chk_valid && !out_free) |=> (r_chk_valid && $stable(r_chk_ymd)))
        else $error("check entry lost under stall");

endmodule

FILE: sv/dspv_parser.sv
`timescale 1ns / 1ps

module dspv_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_char,
    input  logic               i_last,
    output dspv_pkg::t_ymd     o_ymd
);

    logic [dspv_pkg::COUNT_W-1:0] r_count, n_count;
    dspv_pkg::t_field             r_field, n_field;
    dspv_pkg::t_phase             r_phase, n_phase;
    logic [dspv_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [dspv_pkg::ACC_W-1:0]   r_year, n_year;
    logic [dspv_pkg::ACC_W-1:0]   r_month, n_month;
    logic                         r_ended, n_ended;

    logic                             is_digit;
    logic                             is_space;
    logic [dspv_pkg::ACC_EXT_W-1:0]   acc_ext;
    logic [dspv_pkg::ACC_W-1:0]       acc_digit;

    assign is_digit = (i_char >= dspv_pkg::CH_ZERO) && (i_char <= dspv_pkg::CH_NINE);
    assign is_space = (i_char == dspv_pkg::CH_SPACE)
                   || ((i_char >= dspv_pkg::CH_TAB) && (i_char <= dspv_pkg::CH_CR));

    // acc * 10 + digit, saturating
    assign acc_ext = dspv_pkg::ACC_EXT_W'(r_acc) * dspv_pkg::ACC_EXT_W'(10)
                   + dspv_pkg::ACC_EXT_W'(4'(i_char - dspv_pkg::CH_ZERO));
    assign acc_digit = (acc_ext > dspv_pkg::ACC_EXT_W'(dspv_pkg::ACC_LIMIT))
                     ? dspv_pkg::ACC_LIMIT : acc_ext[dspv_pkg::ACC_W-1:0];

    always_comb begin
        n_count = r_count;
        n_field = r_field;
        n_phase = r_phase;
        n_acc   = r_acc;
        n_year  = r_year;
        n_month = r_month;
        n_ended = r_ended;
        if (!r_ended && (r_count < dspv_pkg::COUNT_W'(dspv_pkg::MAX_TEXT_BYTES))) begin
            if (i_char == dspv_pkg::CH_NUL) begin
                n_ended = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
                if (n_count >= dspv_pkg::COUNT_W'(dspv_pkg::MAX_TEXT_BYTES)) begin
                    n_ended = 1'b1;
                end
                if (i_char == dspv_pkg::CH_DASH) begin
                    unique case (r_field)
                        dspv_pkg::FLD_YEAR: begin
                            n_year  = r_acc;
                            n_acc   = '0;
                            n_phase = dspv_pkg::PH_SKIP;
                            n_field = dspv_pkg::FLD_MONTH;
                        end
                        dspv_pkg::FLD_MONTH: begin
                            n_month = r_acc;
                            n_acc   = '0;
                            n_phase = dspv_pkg::PH_SKIP;
                            n_field = dspv_pkg::FLD_DAY;
                        end
                        dspv_pkg::FLD_DAY: begin
                            // third dash closes the day field
                            n_field = dspv_pkg::FLD_PAST;
                        end
                        dspv_pkg::FLD_PAST: begin
                            n_field = dspv_pkg::FLD_PAST;
                        end
                    endcase
                end else if (r_field != dspv_pkg::FLD_PAST) begin
                    unique case (r_phase)
                        dspv_pkg::PH_SKIP: begin
                            if (is_digit) begin
                                n_acc   = acc_digit;
                                n_phase = dspv_pkg::PH_DIGITS;
                            end else if (i_char == dspv_pkg::CH_PLUS) begin
                                n_phase = dspv_pkg::PH_SIGN;
                            end else if (!is_space) begin
                                n_phase = dspv_pkg::PH_DONE;
                            end
                        end
                        dspv_pkg::PH_SIGN,
                        dspv_pkg::PH_DIGITS: begin
                            if (is_digit) begin
                                n_acc   = acc_digit;
                                n_phase = dspv_pkg::PH_DIGITS;
                            end else begin
                                n_phase = dspv_pkg::PH_DONE;
                            end
                        end
                        dspv_pkg::PH_DONE: begin
                            n_phase = dspv_pkg::PH_DONE;
                        end
                    endcase
                end
            end
        end

        // missing fields repeat the previous one
        unique case (n_field)
            dspv_pkg::FLD_YEAR: begin
                o_ymd.year  = n_acc;
                o_ymd.month = n_acc;
                o_ymd.day   = n_acc;
            end
            dspv_pkg::FLD_MONTH: begin
                o_ymd.year  = n_year;
                o_ymd.month = n_acc;
                o_ymd.day   = n_acc;
            end
            dspv_pkg::FLD_DAY,
            dspv_pkg::FLD_PAST: begin
                o_ymd.year  = n_year;
                o_ymd.month = n_month;
                o_ymd.day   = n_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_count <= '0;
            r_field <= dspv_pkg::FLD_YEAR;
            r_phase <= dspv_pkg::PH_SKIP;
            r_acc   <= '0;
            r_year  <= '0;
            r_month <= '0;
            r_ended <= 1'b0;
        end else if (i_step) begin
            r_count <= n_count;
            r_field <= n_field;
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_year  <= n_year;
            r_month <= n_month;
            r_ended <= n_ended;
        end
    end

endmodule

FILE: sv/dspv_check.sv
`timescale 1ns / 1ps

module dspv_check (
    input  dspv_pkg::t_ymd                  i_ymd,
    output logic                            o_ok,
    output logic [dspv_pkg::CODE_W-1:0]     o_code
);

    logic       month_ok;
    logic       year_ok;
    logic       leap;
    logic [4:0] len;
    logic       day_ok;

    assign month_ok = (i_ymd.month >= dspv_pkg::MONTH_JAN)
                   && (i_ymd.month <= dspv_pkg::MONTH_MAX);
    assign year_ok  = (i_ymd.year >= dspv_pkg::YEAR_MIN)
                   && (i_ymd.year <= dspv_pkg::YEAR_MAX)
                   && !((i_ymd.year == dspv_pkg::YEAR_MAX)
                        && (i_ymd.month >= dspv_pkg::MONTH_FEB));

    // inside 1970..2038 every fourth year is leap (2000 included)
    assign leap = (i_ymd.year[1:0] == 2'b00);

    always_comb begin
        len = dspv_pkg::month_len(i_ymd.month[3:0]);
        if ((i_ymd.month == dspv_pkg::MONTH_FEB) && leap) begin
            len = 5'd29;
        end
    end

    assign day_ok = (i_ymd.day != '0) && (i_ymd.day <= dspv_pkg::ACC_W'(len));
    assign o_ok   = month_ok && day_ok && year_ok;

    assign o_code = o_ok
                  ? (dspv_pkg::CODE_W'(i_ymd.year) * dspv_pkg::YEAR_SCALE
                     + dspv_pkg::CODE_W'(i_ymd.month) * dspv_pkg::MONTH_SCALE
                     + dspv_pkg::CODE_W'(i_ymd.day))
                  : '1;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int ITEM_TARGET  = 1750;     // text bytes to offer in total
    localparam int HOLD_CYCLES  = 300;      // long output hold-off
    localparam int HOLD_AT      = 500;      // bytes sent before the hold-off starts
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_code
    logic        s_axis_tlast;   // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [25:0] date_code, [31:26] zero
    logic        m_axis_tuser;   // [0] date_valid

    typedef struct {
        bit                          valid;
        logic [dspv_pkg::CODE_W-1:0] code;
    } t_date_result;

    // tracks the parse of the current text and holds the dates still owed
    class date_scoreboard;
        int unsigned                 taken;
        dspv_pkg::t_field            fld;
        dspv_pkg::t_phase            phase;
        logic [dspv_pkg::ACC_W-1:0]  acc;
        logic [dspv_pkg::ACC_W-1:0]  year_v;
        logic [dspv_pkg::ACC_W-1:0]  month_v;
        bit                          ended;
        t_date_result                dates_owed[$];
        int                          errors;
        int                          checked;
        int                          valid_seen;

        function new();
            clear_text();
            errors     = 0;
            checked    = 0;
            valid_seen = 0;
        endfunction

        function void clear_text();
            taken   = 0;
            fld     = dspv_pkg::FLD_YEAR;
            phase   = dspv_pkg::PH_SKIP;
            acc     = '0;
            year_v  = '0;
            month_v = '0;
            ended   = 1'b0;
        endfunction

        // atoi style digit step, saturating at 9999
        function void take_digit(logic [7:0] c);
            int v;
            v = int'(acc) * 10 + int'(c) - int'(dspv_pkg::CH_ZERO);
            acc = (v > 9999) ? dspv_pkg::ACC_LIMIT : dspv_pkg::ACC_W'(v);
            phase = dspv_pkg::PH_DIGITS;
        endfunction

        function void note_byte(logic [7:0] c, bit last);
            bit           digit;
            bit           space;
            bit           leap;
            bit           ok;
            int           y;
            int           m;
            int           d;
            int           mlen;
            t_date_result r;
            digit = (c >= dspv_pkg::CH_ZERO) && (c <= dspv_pkg::CH_NINE);
            space = (c == dspv_pkg::CH_SPACE)
                    || (c >= dspv_pkg::CH_TAB && c <= dspv_pkg::CH_CR);
            if (!ended && taken < dspv_pkg::MAX_TEXT_BYTES) begin
                if (c == dspv_pkg::CH_NUL) begin
                    ended = 1'b1;
                end else begin
                    if (c == dspv_pkg::CH_DASH) begin
                        if (fld == dspv_pkg::FLD_YEAR) begin
                            year_v = acc;
                        end else if (fld == dspv_pkg::FLD_MONTH) begin
                            month_v = acc;
                        end
                        if (fld == dspv_pkg::FLD_YEAR || fld == dspv_pkg::FLD_MONTH) begin
                            acc   = '0;
                            phase = dspv_pkg::PH_SKIP;
                        end
                        if (fld != dspv_pkg::FLD_PAST) begin
                            fld = dspv_pkg::t_field'(fld + 2'd1);
                        end
                    end else if (fld != dspv_pkg::FLD_PAST) begin
                        case (phase)
                            dspv_pkg::PH_SKIP: begin
                                if (digit) begin
                                    take_digit(c);
                                end else if (c == dspv_pkg::CH_PLUS) begin
                                    phase = dspv_pkg::PH_SIGN;
                                end else if (!space) begin
                                    phase = dspv_pkg::PH_DONE;
                                end
                            end
                            dspv_pkg::PH_SIGN, dspv_pkg::PH_DIGITS: begin
                                if (digit) begin
                                    take_digit(c);
                                end else begin
                                    phase = dspv_pkg::PH_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                    taken++;
                    if (taken >= dspv_pkg::MAX_TEXT_BYTES) begin
                        ended = 1'b1;
                    end
                end
            end
            if (last) begin
                // missing fields repeat the previous one
                case (fld)
                    dspv_pkg::FLD_YEAR: begin
                        y = acc;
                        m = y;
                        d = y;
                    end
                    dspv_pkg::FLD_MONTH: begin
                        y = year_v;
                        m = acc;
                        d = m;
                    end
                    default: begin
                        y = year_v;
                        m = month_v;
                        d = acc;
                    end
                endcase
                leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
                case (m)
                    2:           mlen = leap ? 29 : 28;
                    4, 6, 9, 11: mlen = 30;
                    default:     mlen = 31;
                endcase
                ok = (m >= 1) && (m <= 12) && (d >= 1) && (d <= mlen)
                     && (y >= 1970) && (y <= 2038) && !(y == 2038 && m >= 2);
                r.valid = ok;
                r.code  = ok ? dspv_pkg::CODE_W'(y * 10000 + m * 100 + d) : '1;
                dates_owed.push_back(r);
                clear_text();
            end
        endfunction

        function void check_result(bit valid, logic [31:0] data);
            t_date_result r;
            if (dates_owed.size() == 0) begin
                $error("date result with none owed: valid %0d code %0h", valid, data);
                errors++;
            end else begin
                r = dates_owed.pop_front();
                checked++;
                if (valid) valid_seen++;
                if (valid !== r.valid) begin
                    $error("date_valid mismatch: expected %0d, got %0d", r.valid, valid);
                    errors++;
                end
                if (data[dspv_pkg::CODE_W-1:0] !== r.code) begin
                    $error("date_code mismatch: expected %0d, got %0d",
                           $signed(r.code), $signed(data[dspv_pkg::CODE_W-1:0]));
                    errors++;
                end
                if (data[31:dspv_pkg::CODE_W] !== '0) begin
                    $error("tdata pad mismatch: expected 0, got %0h",
                           data[31:dspv_pkg::CODE_W]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return dates_owed.size();
        endfunction
    endclass

    date_scoreboard sb;
    logic [7:0]     text_buf[$];
    int             bytes_sent;
    int             texts_sent;
    int             cycle_cnt;
    int             hold_left;
    bit             src_idle_on;
    bit             sink_idle_on;

    date_string_parse_validate dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // both sides are observed on pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    // receiver: random stall bursts plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $error("run did not finish within %0d cycles", LIMIT_CYCLES);
        $display("** date_string_parse_validate: FAILED **");
        $finish;
    end

    // offer one byte, at times after a random gap, and wait for the request to be taken
    task automatic send_byte(input logic [7:0] c, input bit last);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        texts_sent++;
        text_buf.delete();
    endtask

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_space();
        return ($urandom_range(0, 1) == 0) ? dspv_pkg::CH_SPACE : 8'($urandom_range(9, 13));
    endfunction

    function automatic string fmt_num(int v);
        return ($urandom_range(0, 1) == 0) ? $sformatf("%02d", v) : $sformatf("%0d", v);
    endfunction

    // mostly well-formed dates near the accepted range, the rest noise and damage
    function automatic void build_text();
        int    kind;
        int    y;
        int    m;
        int    d;
        int    nf;
        int    n;
        int    pos;
        string ys;
        string alphabet;
        text_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 5 || kind == 8) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: y = $urandom_range(1968, 2040);
                7:       y = ($urandom_range(0, 1) == 0) ? 2000 : 1972;
                8:       y = ($urandom_range(0, 1) == 0) ? 2100 : 2038;
                default: y = $urandom_range(0, 9999);
            endcase
            m = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(0, 15);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: d = $urandom_range(28, 31);    // month ends and leap days
                8:          d = $urandom_range(0, 40);
                default:    d = $urandom_range(1, 27);
            endcase
            ys = ($urandom_range(0, 9) == 0) ? $sformatf("%05d", y) : $sformatf("%0d", y);
            if ($urandom_range(0, 5) == 0) text_buf.push_back(pick_space());
            if ($urandom_range(0, 7) == 0) text_buf.push_back(dspv_pkg::CH_PLUS);
            case ($urandom_range(0, 9))
                7:       nf = 2;
                8:       nf = 1;
                9:       nf = 0;    // empty year field
                default: nf = 3;
            endcase
            if (nf != 0) put_str(ys);
            if (nf != 1) begin
                text_buf.push_back(dspv_pkg::CH_DASH);
                if ($urandom_range(0, 9) == 0) text_buf.push_back(pick_space());
                put_str(fmt_num(m));
            end
            if (nf == 3 || nf == 0) begin
                text_buf.push_back(dspv_pkg::CH_DASH);
                put_str(fmt_num(d));
            end
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 4))
                    0:       text_buf.push_back(dspv_pkg::CH_DASH);
                    1:       put_str("T");
                    2:       text_buf.push_back(pick_space());
                    3:       text_buf.push_back(dspv_pkg::CH_NUL);
                    default: text_buf.push_back(dspv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                endcase
            end
            if (kind == 8) begin
                pos = $urandom_range(0, text_buf.size() - 1);
                case ($urandom_range(0, 2))
                    0:       text_buf[pos] = 8'($urandom_range(0, 255));
                    1:       text_buf.insert(pos, dspv_pkg::CH_NUL);
                    default: text_buf.insert(pos, dspv_pkg::CH_DASH);
                endcase
            end
        end else if (kind == 6) begin
            n = $urandom_range(1, 16);
            repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 7) begin
            alphabet = "0123456789-+ \t";
            n = $urandom_range(1, 14);
            repeat (n) begin
                if ($urandom_range(0, 19) == 0) text_buf.push_back(dspv_pkg::CH_NUL);
                else text_buf.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
            end
        end else begin
            // long digit runs saturate the field
            n = $urandom_range(5, 14);
            repeat (n) text_buf.push_back(dspv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0) begin
                text_buf.insert($urandom_range(0, n - 1), dspv_pkg::CH_DASH);
            end
        end
    endfunction

    initial begin
        bit hold_done;
        hold_done     = 1'b0;
        bytes_sent    = 0;
        texts_sent    = 0;
        hold_left     = 0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        sb            = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lowest and highest accepted dates, a lone 0xff, a lone zero byte,
        // and a text where the month field reads as 29
        put_str("1970-1-1");
        send_text();
        put_str("2038-1-31");
        send_text();
        text_buf.push_back(8'hff);
        send_text();
        text_buf.push_back(dspv_pkg::CH_NUL);
        send_text();
        put_str(" 2-29");
        send_text();

        while (bytes_sent < ITEM_TARGET) begin
            if (texts_sent % 16 == 0) begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            // tail of the run goes at full rate
            if (bytes_sent >= ITEM_TARGET * 85 / 100) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            if (!hold_done && bytes_sent >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            build_text();
            send_text();
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d text bytes in %0d texts, %0d dates checked (%0d valid)",
                 bytes_sent, texts_sent, sb.checked, sb.valid_seen);
        $display("run: random stalls on both sides and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("** date_string_parse_validate: PASSED **");
        end else begin
            $display("** date_string_parse_validate: FAILED **");
        end
        $finish;
    end

endmodule
